/* rtl/core/gda_pkg.sv */
// ----------------------------------------------------------------------------
// gda_pkg - shared types and constants for the date adder
// Word type of the shared subtractor, calendar constants, and the struct
// that carries the month and the year phase to the month length lookup.
// ----------------------------------------------------------------------------
package gda_pkg;

    // signed working word: holds a 16-bit day count plus sign and margin
    localparam int WORD_W = 19;
    typedef logic signed [WORD_W-1:0] t_word;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 16;
    localparam int COUNT_W = 16;

    // Gregorian cycle: the leap rule repeats every 400 years
    localparam int YEAR_CYCLE = 400;
    localparam int PHASE_W    = $clog2(YEAR_CYCLE);
    localparam int CENTURY    = 100;

    // remainder by 400 of a 16-bit year: conditional subtracts of 400 << k
    localparam int MOD_STEPS = 8;
    localparam int STEP_W    = $clog2(MOD_STEPS);

    localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_APR = MONTH_W'(4);
    localparam logic [MONTH_W-1:0] MONTH_JUN = MONTH_W'(6);
    localparam logic [MONTH_W-1:0] MONTH_SEP = MONTH_W'(9);
    localparam logic [MONTH_W-1:0] MONTH_NOV = MONTH_W'(11);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

    localparam logic [DAY_W-1:0] LEN_FEB      = DAY_W'(28);
    localparam logic [DAY_W-1:0] LEN_FEB_LEAP = DAY_W'(29);
    localparam logic [DAY_W-1:0] LEN_SHORT    = DAY_W'(30);
    localparam logic [DAY_W-1:0] LEN_LONG     = DAY_W'(31);

    localparam logic [YEAR_W-1:0] YEAR_MAX = '1;

    typedef struct packed {
        logic [MONTH_W-1:0] month;
        logic [PHASE_W-1:0] phase;   // year mod 400
    } t_cal_in;

endpackage

/* rtl/core/gda_sub.sv */
// ----------------------------------------------------------------------------
// gda_sub - shared subtract and compare unit
// Returns a - b and whether a >= b (signed). Used for the year remainder
// steps and for every month step of the walk.
// ----------------------------------------------------------------------------
module gda_sub (
    input  gda_pkg::t_word i_a,
    input  gda_pkg::t_word i_b,
    output gda_pkg::t_word o_diff,
    output logic           o_ge
);

    // operands stay far from the word limits, so the sign bit is exact
    assign o_diff = i_a - i_b;
    assign o_ge   = ~o_diff[gda_pkg::WORD_W-1];

endmodule

/* rtl/core/gda_cal.sv */
// ----------------------------------------------------------------------------
// gda_cal - month length lookup
// Length of a month from its number and the year's position in the
// 400-year cycle. Month codes outside 1..12 count as 31 days.
// ----------------------------------------------------------------------------
module gda_cal (
    input  gda_pkg::t_cal_in                 i_cal,
    output logic [gda_pkg::DAY_W-1:0]        o_len
);

    logic leap;
    logic century;

    // year mod 100 is zero only at these four values of year mod 400
    assign century = i_cal.phase inside {
        gda_pkg::PHASE_W'(0),
        gda_pkg::PHASE_W'(gda_pkg::CENTURY),
        gda_pkg::PHASE_W'(2 * gda_pkg::CENTURY),
        gda_pkg::PHASE_W'(3 * gda_pkg::CENTURY)
    };

    assign leap = ((i_cal.phase[1:0] == 2'b00) && !century) ||
                  (i_cal.phase == '0);

    always_comb begin
        case (i_cal.month)
            gda_pkg::MONTH_FEB: o_len = leap ? gda_pkg::LEN_FEB_LEAP : gda_pkg::LEN_FEB;
            gda_pkg::MONTH_APR,
            gda_pkg::MONTH_JUN,
            gda_pkg::MONTH_SEP,
            gda_pkg::MONTH_NOV: o_len = gda_pkg::LEN_SHORT;
            default:            o_len = gda_pkg::LEN_LONG;
        endcase
    end

endmodule

/* rtl/core/gregorian_date_add_days.sv */
// ----------------------------------------------------------------------------
// gregorian_date_add_days - Gregorian date plus a day count
// Each item passes the year remainder steps, the month walk and the output
// load; the walk runs up to about 2160 months for the largest count. One item
// at a time. Throughput is set by the month walk: one month per cycle through
// the shared subtractor. Reset (i_rst_n low, synchronous) returns to idle and
// drops any pending result.
// ----------------------------------------------------------------------------
module gregorian_date_add_days (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [4:0] start_day, [8:5] start_month, [24:9] start_year,
    // [40:25] days_to_add, [47:41] zero
    input  logic [47:0] i_s_axis_tdata,
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [4:0] end_day, [8:5] end_month, [24:9] end_year,
    // [25] year_overflow, [31:26] zero
    output logic [31:0] o_m_axis_tdata
);

    // Sequencer:
    //   IDLE  wait for an input transfer
    //   MOD   year mod 400 by eight conditional subtracts of 400 << k
    //   WALK  one month per cycle; the phase of the year then just counts
    //   DONE  load the output register once it is free
    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_WALK,
        S_DONE
    } t_state;

    t_state                          r_state;
    logic [gda_pkg::DAY_W-1:0]       r_day;
    logic [gda_pkg::MONTH_W-1:0]     r_month;
    logic [gda_pkg::YEAR_W-1:0]      r_year;
    gda_pkg::t_word                  r_left;    // days still to add, never negative
    logic [gda_pkg::YEAR_W-1:0]      r_rem;     // remainder by 400; low bits are phase
    logic [gda_pkg::STEP_W-1:0]      r_k;
    logic                            r_ovf;
    logic                            r_out_valid;
    logic [31:0]                     r_out_data;

    gda_pkg::t_word                  sub_a;
    gda_pkg::t_word                  sub_b;
    gda_pkg::t_word                  sub_diff;
    logic                            sub_ge;
    gda_pkg::t_cal_in                cal_in;
    logic [gda_pkg::DAY_W-1:0]       month_len;
    logic signed [gda_pkg::DAY_W+1:0] rest;
    logic [gda_pkg::PHASE_W-1:0]     phase;
    logic                            out_free;

    assign phase = r_rem[gda_pkg::PHASE_W-1:0];

    assign cal_in.month = r_month;
    assign cal_in.phase = phase;

    gda_cal u_cal (
        .i_cal (cal_in),
        .o_len (month_len)
    );

    // days left in the current month, counting the current day;
    // zero or negative when the day is past the month's end
    assign rest = $signed({2'b00, month_len}) - $signed({2'b00, r_day})
                + $signed((gda_pkg::DAY_W+2)'(1));

    always_comb begin
        case (r_state)
            S_MOD: begin
                sub_a = gda_pkg::t_word'({3'b000, r_rem});
                sub_b = gda_pkg::t_word'(gda_pkg::YEAR_CYCLE) << r_k;
            end
            default: begin
                sub_a = r_left;
                sub_b = {{(gda_pkg::WORD_W-gda_pkg::DAY_W-2){rest[gda_pkg::DAY_W+1]}}, rest};
            end
        endcase
    end

    gda_sub u_sub (
        .i_a    (sub_a),
        .i_b    (sub_b),
        .o_diff (sub_diff),
        .o_ge   (sub_ge)
    );

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // in DONE the register is reloaded in the same cycle instead
            if (r_out_valid && i_m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_day   <= i_s_axis_tdata[4:0];
                        r_month <= i_s_axis_tdata[8:5];
                        r_year  <= i_s_axis_tdata[24:9];
                        r_rem   <= i_s_axis_tdata[24:9];
                        r_left  <= gda_pkg::t_word'({3'b000, i_s_axis_tdata[40:25]});
                        r_k     <= gda_pkg::STEP_W'(gda_pkg::MOD_STEPS - 1);
                        r_ovf   <= 1'b0;
                        r_state <= S_MOD;
                    end
                end

                S_MOD: begin
                    if (sub_ge) begin
                        r_rem <= sub_diff[gda_pkg::YEAR_W-1:0];
                    end
                    if (r_k == '0) begin
                        r_state <= S_WALK;
                    end else begin
                        r_k <= r_k - gda_pkg::STEP_W'(1);
                    end
                end

                S_WALK: begin
                    if (r_left == '0) begin
                        r_state <= S_DONE;
                    end else if (sub_ge) begin
                        // leave the month whole, continue at day 1 of the next
                        r_left <= sub_diff;
                        r_day  <= gda_pkg::DAY_W'(1);
                        if (r_month == gda_pkg::MONTH_DEC) begin
                            r_month <= gda_pkg::MONTH_JAN;
                            if (r_year == gda_pkg::YEAR_MAX) begin
                                r_ovf <= 1'b1;    // year saturates, walk goes on
                            end else begin
                                r_year <= r_year + gda_pkg::YEAR_W'(1);
                                if (phase == gda_pkg::PHASE_W'(gda_pkg::YEAR_CYCLE - 1)) begin
                                    r_rem <= '0;
                                end else begin
                                    r_rem <= r_rem + gda_pkg::YEAR_W'(1);
                                end
                            end
                        end else begin
                            r_month <= r_month + gda_pkg::MONTH_W'(1);
                        end
                    end else begin
                        // remaining count ends inside this month
                        r_day   <= r_day + r_left[gda_pkg::DAY_W-1:0];
                        r_left  <= '0;
                        r_state <= S_DONE;
                    end
                end

                S_DONE: begin
                    if (out_free) begin
                        r_out_data  <= {6'b000000, r_ovf, r_year, r_month, r_day};
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb - self-checking bench for gregorian_date_add_days
// Drives start dates and day counts over the input stream and predicts each
// end date with a month-by-month calendar walk. Every result transfer is
// checked field by field against the oldest prediction. Directed cases cover
// zero counts, leap rules, out-of-range days and months and year saturation.
// A random mix of calendar dates, long walks and noise follows. The sender
// works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb;

    localparam int     HALF_PERIOD   = 5;
    localparam int     RANDOM_ITEMS  = 248;
    // wait one more worst-case walk for stray results
    localparam int     TAIL_CYCLES   = 2400;
    localparam int     REPORT_LIMIT  = 10;
    localparam longint RUN_LIMIT     = 64'd40_000_000;

    typedef struct packed {
        logic [gda_pkg::DAY_W-1:0]   day;
        logic [gda_pkg::MONTH_W-1:0] month;
        logic [gda_pkg::YEAR_W-1:0]  year;
        logic                        ovf;
    } t_date_result;

    // receiver behavior for the current stretch
    typedef enum logic [1:0] {
        RX_STEADY,
        RX_CHOPPY,
        RX_HOLD
    } t_rx_mode;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        s_valid = 1'b0;
    logic [47:0] s_data  = '0;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [31:0] m_data;

    t_date_result expected_dates[$];

    int       burst_left   = 0;
    int       hold_left    = 0;
    t_rx_mode rx_mode      = RX_STEADY;
    int       items_sent   = 0;
    int       results_seen = 0;
    int       errors       = 0;
    int       ovf_results  = 0;
    int       long_walks   = 0;
    int       odd_dates    = 0;

    gregorian_date_add_days dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------------
    function automatic bit is_leap_year(input logic [gda_pkg::YEAR_W-1:0] y);
        return ((y % 4) == 0 && (y % gda_pkg::CENTURY) != 0) ||
               ((y % gda_pkg::YEAR_CYCLE) == 0);
    endfunction

    // months outside 1..12 count as long months
    function automatic int days_in_month(input logic [gda_pkg::MONTH_W-1:0] m,
                                         input logic [gda_pkg::YEAR_W-1:0]  y);
        if (m == gda_pkg::MONTH_FEB)
            return is_leap_year(y) ? int'(gda_pkg::LEN_FEB_LEAP) : int'(gda_pkg::LEN_FEB);
        if (m == gda_pkg::MONTH_APR || m == gda_pkg::MONTH_JUN ||
            m == gda_pkg::MONTH_SEP || m == gda_pkg::MONTH_NOV)
            return int'(gda_pkg::LEN_SHORT);
        return int'(gda_pkg::LEN_LONG);
    endfunction

    function automatic t_date_result add_days_to_date(
        input logic [gda_pkg::DAY_W-1:0]   d0,
        input logic [gda_pkg::MONTH_W-1:0] m0,
        input logic [gda_pkg::YEAR_W-1:0]  y0,
        input logic [gda_pkg::COUNT_W-1:0] n
    );
        t_date_result                r;
        int                          day;
        int                          rest;
        int                          left;
        logic [gda_pkg::MONTH_W-1:0] month;
        logic [gda_pkg::YEAR_W-1:0]  year;
        logic                        ovf;
        day   = int'(d0);
        month = m0;
        year  = y0;
        left  = int'(n);
        ovf   = 1'b0;
        while (left > 0) begin
            // signed: a day past the month end gives zero or less here
            rest = days_in_month(month, year) - day + 1;
            if (left >= rest) begin
                left -= rest;
                day   = 1;
                if (month == gda_pkg::MONTH_DEC) begin
                    month = gda_pkg::MONTH_JAN;
                    if (year == gda_pkg::YEAR_MAX)
                        ovf = 1'b1;
                    else
                        year = year + 1'b1;
                end else begin
                    month = month + 1'b1;   // 4-bit wrap, 15 -> 0
                end
            end else begin
                day += left;
                left = 0;
            end
        end
        r.day   = day[gda_pkg::DAY_W-1:0];
        r.month = month;
        r.year  = year;
        r.ovf   = ovf;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: one transfer per call, bursts with random gaps in between
    // ------------------------------------------------------------------------
    task automatic send_date(input logic [gda_pkg::DAY_W-1:0]   day,
                             input logic [gda_pkg::MONTH_W-1:0] month,
                             input logic [gda_pkg::YEAR_W-1:0]  year,
                             input logic [gda_pkg::COUNT_W-1:0] count);
        @(negedge clk);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            // long bursts give stretches with no sender gaps
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= {7'd0, count, year, month, day};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        expected_dates.push_back(add_days_to_date(day, month, year, count));
        items_sent++;
        if (count > 16'd2000)
            long_walks++;
    endtask

    // pause the sender until every predicted result has come back
    task automatic drain_results;
        @(negedge clk);
        s_valid <= 1'b0;
        while (expected_dates.size() != 0) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: ready pattern in stretches of steady, choppy or held low
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (hold_left == 0) begin
            rx_mode   = t_rx_mode'($urandom_range(0, 2));
            hold_left = (rx_mode == RX_STEADY) ? $urandom_range(20, 200)
                                               : $urandom_range(1, 30);
        end else begin
            hold_left--;
        end
        case (rx_mode)
            RX_STEADY: begin
                m_ready <= 1'b1;
            end
            RX_CHOPPY: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
                m_ready <= 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        t_date_result want;
        t_date_result got;
        if (rst_n && m_valid && m_ready) begin
            got.day   = m_data[4:0];
            got.month = m_data[8:5];
            got.year  = m_data[24:9];
            got.ovf   = m_data[25];
            results_seen++;
            if (expected_dates.size() == 0) begin
                if (errors < REPORT_LIMIT)
                    $display("unexpected result transfer: data %h", m_data);
                errors++;
            end else begin
                want = expected_dates.pop_front();
                if (want.ovf)
                    ovf_results++;
                if (got.day !== want.day || got.month !== want.month ||
                    got.year !== want.year || got.ovf !== want.ovf ||
                    m_data[31:26] !== 6'd0) begin
                    if (errors < REPORT_LIMIT)
                        $display({"result %0d mismatch: expected %0d/%0d/%0d ovf %0d, ",
                                  "got %0d/%0d/%0d ovf %0d pad %b"},
                                 results_seen, want.day, want.month, want.year, want.ovf,
                                 got.day, got.month, got.year, got.ovf, m_data[31:26]);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------
    // zero count returns the start date as is, even when out of range
    task automatic test_zero_count;
        send_date(5'd31, 4'd2,  16'd2023,  16'd0);
        send_date(5'd0,  4'd0,  16'd0,     16'd0);
        send_date(5'd31, 4'd15, 16'hFFFF,  16'd0);
    endtask

    task automatic test_leap_rules;
        send_date(5'd28, 4'd2,  16'd2024, 16'd1);   // plain leap year
        send_date(5'd28, 4'd2,  16'd2023, 16'd1);   // common year
        send_date(5'd28, 4'd2,  16'd1900, 16'd1);   // century, not leap
        send_date(5'd28, 4'd2,  16'd2000, 16'd1);   // divisible by 400
        send_date(5'd1,  4'd1,  16'd2100, 16'd365);
        send_date(5'd31, 4'd12, 16'd1999, 16'd1);   // December rollover
    endtask

    task automatic test_month_ends;
        send_date(5'd30, 4'd4, 16'd2021, 16'd1);
        send_date(5'd31, 4'd1, 16'd2022, 16'd31);
        send_date(5'd1,  4'd1, 16'd0,    16'hFFFF); // largest count from year 0
    endtask

    // days past the month end, day zero, months outside 1..12
    task automatic test_odd_dates;
        send_date(5'd31, 4'd4,  16'd2021, 16'd1);
        send_date(5'd30, 4'd2,  16'd2023, 16'd3);
        send_date(5'd0,  4'd3,  16'd2020, 16'd5);
        send_date(5'd15, 4'd0,  16'd2020, 16'd20);
        send_date(5'd10, 4'd15, 16'd2020, 16'd40);
        send_date(5'd20, 4'd13, 16'd2019, 16'd100);
        odd_dates += 6;
    endtask

    task automatic test_year_overflow;
        send_date(5'd31, 4'd12, 16'hFFFF, 16'd1);
        send_date(5'd1,  4'd1,  16'hFFFF, 16'hFFFF);
        send_date(5'd31, 4'd12, 16'hFFFE, 16'd400);
        send_date(5'd1,  4'd1,  16'hFFFF, 16'd1);
    endtask

    // ------------------------------------------------------------------------
    // Random mix
    // ------------------------------------------------------------------------
    function automatic logic [gda_pkg::YEAR_W-1:0] pick_year;
        case ($urandom_range(0, 3))
            0: return gda_pkg::YEAR_W'($urandom);
            1: return gda_pkg::YEAR_W'($urandom_range(1, 655) * gda_pkg::CENTURY +
                                       $urandom_range(0, 2) - 1);
            2: return gda_pkg::YEAR_W'($urandom_range(65528, 65535));
            default: return gda_pkg::YEAR_W'($urandom_range(1890, 2110));
        endcase
    endfunction

    task automatic test_random_dates;
        logic [gda_pkg::DAY_W-1:0]   day;
        logic [gda_pkg::MONTH_W-1:0] month;
        logic [gda_pkg::YEAR_W-1:0]  year;
        logic [gda_pkg::COUNT_W-1:0] count;
        int                          pick;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pick  = $urandom_range(0, 99);
            year  = pick_year();
            month = gda_pkg::MONTH_W'($urandom_range(1, 12));
            day   = gda_pkg::DAY_W'($urandom_range(1, days_in_month(month, year)));
            if (pick < 55) begin
                // well-formed date, short to medium walk
                count = gda_pkg::COUNT_W'($urandom_range(0, 800));
            end else if (pick < 70) begin
                // full count range, walks of up to ~2160 months
                count = gda_pkg::COUNT_W'($urandom);
            end else if (pick < 85) begin
                // anything the fields allow
                day   = gda_pkg::DAY_W'($urandom);
                month = gda_pkg::MONTH_W'($urandom);
                count = gda_pkg::COUNT_W'($urandom_range(0, 2000));
                odd_dates++;
            end else begin
                // close to the top year so the saturation kicks in
                year  = gda_pkg::YEAR_W'($urandom_range(65530, 65535));
                count = gda_pkg::COUNT_W'($urandom_range(0, 3000));
            end
            send_date(day, month, year, count);
            if (i == RANDOM_ITEMS / 2)
                drain_results();
        end
    endtask

    // ------------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------------
    initial begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        test_zero_count();
        test_leap_rules();
        test_month_ends();
        test_odd_dates();
        test_year_overflow();
        drain_results();
        test_random_dates();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("%0d dates sent, %0d results checked, %0d errors", items_sent,
                 results_seen, errors);
        $display("%0d walks over 2000 days, %0d off-calendar starts, %0d saturated years",
                 long_walks, odd_dates, ovf_results);
        if (errors == 0 && expected_dates.size() == 0) begin
            $display("** gregorian_date_add_days: PASSED **");
        end else begin
            $display("** gregorian_date_add_days: FAILED **");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("timeout: %0d results still pending", expected_dates.size());
        $display("** gregorian_date_add_days: FAILED **");
        $finish;
    end

endmodule

/* files.f */
rtl/core/gda_pkg.sv
rtl/core/gda_sub.sv
rtl/core/gda_cal.sv
rtl/core/gregorian_date_add_days.sv
tb/sv/tb.sv
